// File: rtl/core/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int ProdBits = 2 * WordBits;
  localparam int SumBits  = ProdBits + 1;
  localparam int NumBits  = 3 * WordBits;
  localparam int QBits    = WordBits;

  typedef enum logic [2:0] {
    OpAdd   = 3'd0,
    OpSub   = 3'd1,
    OpMul   = 3'd2,
    OpDiv   = 3'd3,
    OpConj  = 3'd4,
    OpRecip = 3'd5,
    OpMag   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StSat     = 2'd1,
    StDivZero = 2'd2
  } status_e;

  typedef logic [ProdBits-1:0] mag_t;
  typedef logic [WordBits-1:0] word_t;

  typedef struct packed {
    logic  sat;
    word_t w;
  } packed_t;

  typedef struct packed {
    op_e   op;
    logic  dz;
    logic  neg_re;
    logic  neg_im;
    logic  ovf_re;
    logic  ovf_im;
    word_t w_re;
    word_t w_im;
    logic  w_sat;
    mag_t  d;
  } ctl_t;

  typedef struct packed {
    mag_t  r;
    word_t nlo;
    word_t q;
  } div_lane_t;

  typedef struct packed {
    mag_t rem;
    mag_t root;
  } sqrt_t;

  // Clamp a sign-magnitude value to the signed word range.
  function automatic packed_t sat_pack(input logic neg, input mag_t mag);
    mag_t    half;
    packed_t p;
    half  = mag_t'(1) << (WordBits - 1);
    p.sat = neg ? (mag > half) : (mag >= half);
    if (p.sat) begin
      p.w = neg ? word_t'(half) : word_t'(half - mag_t'(1));
    end else begin
      p.w = neg ? (~mag[WordBits-1:0] + word_t'(1)) : mag[WordBits-1:0];
    end
    return p;
  endfunction

  // One restoring quotient bit: shift in the next dividend bit, subtract if it fits.
  function automatic div_lane_t div_step(input div_lane_t x, input mag_t d);
    logic [ProdBits:0] t;
    logic [ProdBits:0] diff;
    logic              ge;
    div_lane_t         y;
    t     = {x.r, x.nlo[QBits-1]};
    diff  = t - {1'b0, d};
    ge    = (t >= {1'b0, d});
    y.r   = ge ? diff[ProdBits-1:0] : t[ProdBits-1:0];
    y.nlo = {x.nlo[QBits-2:0], 1'b0};
    y.q   = {x.q[QBits-2:0], ge};
    return y;
  endfunction

  // One root bit of the digit-by-digit square root.
  function automatic sqrt_t sqrt_step(input sqrt_t x, input mag_t b);
    mag_t  trial;
    sqrt_t y;
    trial = x.root + b;
    if (x.rem >= trial) begin
      y.rem  = x.rem - trial;
      y.root = (x.root >> 1) + b;
    end else begin
      y.rem  = x.rem;
      y.root = x.root >> 1;
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Complex arithmetic on signed Q16.16 operands: add, subtract, multiply, divide,
// conjugate, reciprocal and magnitude, one result word per input word. The unit
// takes a new word every clock while the output is not stalled. The quotient and
// square-root section resolves one result bit per pipeline stage over 32 stages,
// behind three stages of multiply, sum and absolute value and one setup stage. A
// stall on the output holds the whole pipeline, and the input stalls with it.
// Overflowing results saturate with status 1; a zero divisor (or zero operand for
// reciprocal) gives zero with status 2.
module complex_arithmetic_unit_core
  import cau_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 op_i,
  input  logic signed [WordBits-1:0] a_re_i,
  input  logic signed [WordBits-1:0] a_im_i,
  input  logic signed [WordBits-1:0] b_re_i,
  input  logic signed [WordBits-1:0] b_im_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [WordBits-1:0] res_re_o,
  output logic signed [WordBits-1:0] res_im_o,
  output logic [1:0]                 status_o
);

  logic en;

  // stage 1: products and the simple operations
  logic signed [WordBits:0]   sr, si;
  logic [WordBits:0]          mr, mi;
  packed_t                    pr1, pi1;
  logic signed [WordBits-1:0] m0, m1;
  op_e                        op_in;

  logic                       v1_q;
  ctl_t                       c1_d, c1_q;
  logic signed [ProdBits-1:0] sq_a_d, sq_b_d, p_rr_d, p_ii_d, p_ri_d, p_ir_d;
  logic signed [ProdBits-1:0] sq_a_q, sq_b_q, p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [WordBits-1:0] ar1_q, ai1_q;

  // stage 2: sums
  logic                       v2_q;
  ctl_t                       c2_d, c2_q;
  logic signed [SumBits-1:0]  s2_re_d, s2_im_d, s2_re_q, s2_im_q;

  // stage 3: absolute values
  logic                       v3_q;
  ctl_t                       c3_d, c3_q;
  logic [SumBits-1:0]         ab_re, ab_im;
  mag_t                       m3_re_q, m3_im_q;

  // stage 4 and the bit stages
  logic [NumBits-1:0]         num_re, num_im;
  packed_t                    pm_re, pm_im;
  logic                       vs_q  [0:QBits];
  ctl_t                       ctl_q [0:QBits];
  div_lane_t                  dre_q [0:QBits];
  div_lane_t                  dim_q [0:QBits];
  sqrt_t                      sq_q  [0:QBits];
  ctl_t                       ctl0_d;
  div_lane_t                  dre0_d, dim0_d;
  sqrt_t                      sq0_d;

  // output
  ctl_t                       cf;
  packed_t                    fr, fi;
  logic                       out_valid_q;
  word_t                      res_re_d, res_im_d, res_re_q, res_im_q;
  status_e                    st_d, st_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign op_in      = op_e'(op_i);

  always_comb begin
    sr = '0;
    si = '0;
    case (op_in)
      OpAdd: begin
        sr = (WordBits+1)'(a_re_i) + (WordBits+1)'(b_re_i);
        si = (WordBits+1)'(a_im_i) + (WordBits+1)'(b_im_i);
      end
      OpSub: begin
        sr = (WordBits+1)'(a_re_i) - (WordBits+1)'(b_re_i);
        si = (WordBits+1)'(a_im_i) - (WordBits+1)'(b_im_i);
      end
      OpConj: begin
        sr = (WordBits+1)'(a_re_i);
        si = -(WordBits+1)'(a_im_i);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    mr  = sr[WordBits] ? (~sr + 1'b1) : sr;
    mi  = si[WordBits] ? (~si + 1'b1) : si;
    pr1 = sat_pack(sr[WordBits], mag_t'(mr));
    pi1 = sat_pack(si[WordBits], mag_t'(mi));

    m0     = (op_in == OpDiv) ? b_re_i : a_re_i;
    m1     = (op_in == OpDiv) ? b_im_i : a_im_i;
    sq_a_d = ProdBits'(m0) * ProdBits'(m0);
    sq_b_d = ProdBits'(m1) * ProdBits'(m1);
    p_rr_d = ProdBits'(a_re_i) * ProdBits'(b_re_i);
    p_ii_d = ProdBits'(a_im_i) * ProdBits'(b_im_i);
    p_ri_d = ProdBits'(a_re_i) * ProdBits'(b_im_i);
    p_ir_d = ProdBits'(a_im_i) * ProdBits'(b_re_i);

    c1_d        = '0;
    c1_d.op     = op_in;
    c1_d.w_re   = pr1.w;
    c1_d.w_im   = pi1.w;
    c1_d.w_sat  = pr1.sat | pi1.sat;
  end

  always_comb begin
    c2_d   = c1_q;
    c2_d.d = mag_t'(sq_a_q) + mag_t'(sq_b_q);
    case (c1_q.op)
      OpMul: begin
        s2_re_d = SumBits'(p_rr_q) - SumBits'(p_ii_q);
        s2_im_d = SumBits'(p_ri_q) + SumBits'(p_ir_q);
      end
      OpDiv: begin
        s2_re_d = SumBits'(p_rr_q) + SumBits'(p_ii_q);
        s2_im_d = SumBits'(p_ir_q) - SumBits'(p_ri_q);
      end
      OpRecip: begin
        s2_re_d = SumBits'(ar1_q);
        s2_im_d = -SumBits'(ai1_q);
      end
      default: begin
        s2_re_d = '0;
        s2_im_d = '0;
      end
    endcase
  end

  always_comb begin
    ab_re       = s2_re_q[SumBits-1] ? (~s2_re_q + 1'b1) : s2_re_q;
    ab_im       = s2_im_q[SumBits-1] ? (~s2_im_q + 1'b1) : s2_im_q;
    c3_d        = c2_q;
    c3_d.dz     = (c2_q.d == '0);
    c3_d.neg_re = s2_re_q[SumBits-1];
    c3_d.neg_im = s2_im_q[SumBits-1];
  end

  // Align the dividend; a top part not below the divisor means the quotient overflows.
  always_comb begin
    if (c3_q.op == OpRecip) begin
      num_re = NumBits'(m3_re_q) << (2 * FracBits);
      num_im = NumBits'(m3_im_q) << (2 * FracBits);
    end else begin
      num_re = NumBits'(m3_re_q) << FracBits;
      num_im = NumBits'(m3_im_q) << FracBits;
    end
    dre0_d.r   = num_re[NumBits-1:QBits];
    dre0_d.nlo = num_re[QBits-1:0];
    dre0_d.q   = '0;
    dim0_d.r   = num_im[NumBits-1:QBits];
    dim0_d.nlo = num_im[QBits-1:0];
    dim0_d.q   = '0;
    sq0_d.rem  = c3_q.d;
    sq0_d.root = '0;

    pm_re = sat_pack(c3_q.neg_re, m3_re_q >> FracBits);
    pm_im = sat_pack(c3_q.neg_im, m3_im_q >> FracBits);

    ctl0_d        = c3_q;
    ctl0_d.ovf_re = (dre0_d.r >= c3_q.d);
    ctl0_d.ovf_im = (dim0_d.r >= c3_q.d);
    if (c3_q.op == OpMul) begin
      ctl0_d.w_re  = pm_re.w;
      ctl0_d.w_im  = pm_im.w;
      ctl0_d.w_sat = pm_re.sat | pm_im.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      vs_q[0]  <= 1'b0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      vs_q[0]  <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q     <= c1_d;
      sq_a_q   <= sq_a_d;
      sq_b_q   <= sq_b_d;
      p_rr_q   <= p_rr_d;
      p_ii_q   <= p_ii_d;
      p_ri_q   <= p_ri_d;
      p_ir_q   <= p_ir_d;
      ar1_q    <= a_re_i;
      ai1_q    <= a_im_i;
      c2_q     <= c2_d;
      s2_re_q  <= s2_re_d;
      s2_im_q  <= s2_im_d;
      c3_q     <= c3_d;
      m3_re_q  <= ab_re[ProdBits-1:0];
      m3_im_q  <= ab_im[ProdBits-1:0];
      ctl_q[0] <= ctl0_d;
      dre_q[0] <= dre0_d;
      dim_q[0] <= dim0_d;
      sq_q[0]  <= sq0_d;
    end
  end

  for (genvar k = 0; k < QBits; k++) begin : g_bit
    localparam mag_t SqBit = mag_t'(1) << (ProdBits - 2 - 2 * k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (en) begin
        vs_q[k+1] <= vs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ctl_q[k+1] <= ctl_q[k];
        dre_q[k+1] <= div_step(dre_q[k], ctl_q[k].d);
        dim_q[k+1] <= div_step(dim_q[k], ctl_q[k].d);
        sq_q[k+1]  <= sqrt_step(sq_q[k], SqBit);
      end
    end
  end

  always_comb begin
    cf       = ctl_q[QBits];
    fr       = sat_pack(cf.neg_re, cf.ovf_re ? (mag_t'(1) << WordBits) : mag_t'(dre_q[QBits].q));
    fi       = sat_pack(cf.neg_im, cf.ovf_im ? (mag_t'(1) << WordBits) : mag_t'(dim_q[QBits].q));
    res_re_d = '0;
    res_im_d = '0;
    st_d     = StOk;
    case (cf.op) inside
      OpAdd, OpSub, OpMul, OpConj: begin
        res_re_d = cf.w_re;
        res_im_d = cf.w_im;
        st_d     = cf.w_sat ? StSat : StOk;
      end
      OpDiv, OpRecip: begin
        if (cf.dz) begin
          st_d = StDivZero;
        end else begin
          res_re_d = fr.w;
          res_im_d = fi.w;
          st_d     = (fr.sat | fi.sat) ? StSat : StOk;
        end
      end
      OpMag: begin
        fr       = sat_pack(1'b0, sq_q[QBits].root);
        res_re_d = fr.w;
        st_d     = fr.sat ? StSat : StOk;
      end
      default: begin
        st_d = StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vs_q[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      st_q     <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign status_o    = st_q;

endmodule

`default_nettype wire
